[hw/rtl/tlca_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlca_pkg: shared types and constants
// Beat formats, table geometry and a helper for the binary-lifting LCA block.
// ----------------------------------------------------------------------------
package tlca_pkg;

    localparam int NODE_W    = 10;
    localparam int MAX_NODES = 1 << NODE_W;
    localparam int LEVELS    = 10;
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int JT_AW     = NODE_W + LVL_W;
    localparam int JT_DEPTH  = 1 << JT_AW;

    localparam logic [NODE_W-1:0] DEPTH_MAX = NODE_W'(MAX_NODES - 1);
    localparam logic [LVL_W-1:0]  LVL_TOP   = LVL_W'(LEVELS - 1);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } req_t;

    typedef struct packed {
        logic [NODE_W-1:0] ancestor;
        logic              status;
    } resp_t;

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] depth;
    } info_t;

    localparam int INFO_W = $bits(info_t);

    function automatic logic [LVL_W-1:0] jump_level(input logic [NODE_W-1:0] v);
        int p;
        p = 0;
        for (int i = 0; i < NODE_W; i++)
        begin
            if (v[i])
            begin
                p = i;
            end
        end
        if (p > LEVELS - 1)
        begin
            p = LEVELS - 1;
        end
        return LVL_W'(p);
    endfunction

endpackage

[hw/rtl/tlca_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlca_ram: generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module tlca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem_reg[rd_addr_a];
        rd_b_reg <= mem_reg[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

[hw/rtl/tlca_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlca_ctrl: table sequencer
// Holds the node info and jump tables and walks them one level per step
// for inserts, leveling and joint lifting.
// ----------------------------------------------------------------------------
module tlca_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  tlca_pkg::req_t   req,
    output logic             res_valid,
    input  logic             res_ready,
    output tlca_pkg::resp_t  res
);

    typedef enum logic [12:0] {
        S_CLEAR   = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_INFO    = 13'b0000000000100,
        S_INS_RD  = 13'b0000000001000,
        S_INS_WR  = 13'b0000000010000,
        S_INS_END = 13'b0000000100000,
        S_LVL_RD  = 13'b0000001000000,
        S_LVL_WR  = 13'b0000010000000,
        S_LIFT_RD = 13'b0000100000000,
        S_LIFT_WR = 13'b0001000000000,
        S_LAST_RD = 13'b0010000000000,
        S_LAST_WR = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [tlca_pkg::NODE_W-1:0] clr_reg, clr_next;
    tlca_pkg::req_t              item_reg, item_next;
    logic [tlca_pkg::NODE_W-1:0] d_reg, d_next;
    logic [tlca_pkg::NODE_W-1:0] x_reg, x_next;
    logic [tlca_pkg::NODE_W-1:0] y_reg, y_next;
    logic [tlca_pkg::LVL_W-1:0]  lvl_reg, lvl_next;
    logic                        zx_reg, zx_next;
    logic                        zy_reg, zy_next;
    tlca_pkg::resp_t             res_reg, res_next;

    logic                          info_we;
    logic [tlca_pkg::NODE_W-1:0]   info_waddr;
    logic [tlca_pkg::INFO_W-1:0]   info_wdata;
    logic [tlca_pkg::NODE_W-1:0]   info_raddr_a, info_raddr_b;
    logic [tlca_pkg::INFO_W-1:0]   info_rdata_a, info_rdata_b;
    tlca_pkg::info_t               info_a, info_b;

    logic                          jt_we;
    logic [tlca_pkg::JT_AW-1:0]    jt_waddr;
    logic [tlca_pkg::NODE_W-1:0]   jt_wdata;
    logic [tlca_pkg::JT_AW-1:0]    jt_raddr_a, jt_raddr_b;
    logic [tlca_pkg::NODE_W-1:0]   jt_rdata_a, jt_rdata_b;
    logic [tlca_pkg::NODE_W-1:0]   anc_a, anc_b;

    logic [tlca_pkg::LVL_W-1:0]    lvl_prev;
    logic                          self_ref;
    logic                          span_ok;
    logic                          need_rd;
    logic [tlca_pkg::LVL_W-1:0]    jq;

    tlca_ram #(
        .WIDTH (tlca_pkg::INFO_W),
        .DEPTH (tlca_pkg::MAX_NODES)
    ) u_info_ram (
        .clk       (clk),
        .wr_en     (info_we),
        .wr_addr   (info_waddr),
        .wr_data   (info_wdata),
        .rd_addr_a (info_raddr_a),
        .rd_data_a (info_rdata_a),
        .rd_addr_b (info_raddr_b),
        .rd_data_b (info_rdata_b)
    );

    tlca_ram #(
        .WIDTH (tlca_pkg::NODE_W),
        .DEPTH (tlca_pkg::JT_DEPTH)
    ) u_jump_ram (
        .clk       (clk),
        .wr_en     (jt_we),
        .wr_addr   (jt_waddr),
        .wr_data   (jt_wdata),
        .rd_addr_a (jt_raddr_a),
        .rd_data_a (jt_rdata_a),
        .rd_addr_b (jt_raddr_b),
        .rd_data_b (jt_rdata_b)
    );

    assign info_a   = tlca_pkg::info_t'(info_rdata_a);
    assign info_b   = tlca_pkg::info_t'(info_rdata_b);
    assign anc_a    = zx_reg ? '0 : jt_rdata_a;
    assign anc_b    = zy_reg ? '0 : jt_rdata_b;
    assign lvl_prev = lvl_reg - tlca_pkg::LVL_W'(1);
    assign self_ref = (item_reg.node_a == item_reg.node_b);
    assign span_ok  = ((d_reg >> lvl_reg) != '0);
    assign need_rd  = span_ok && (x_reg != '0) && ((x_reg != item_reg.node_a) || self_ref);
    assign jq       = tlca_pkg::jump_level(d_reg);

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        item_next    = item_reg;
        d_next       = d_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        lvl_next     = lvl_reg;
        zx_next      = zx_reg;
        zy_next      = zy_reg;
        res_next     = res_reg;

        info_we      = 1'b0;
        info_waddr   = item_reg.node_a;
        info_wdata   = '0;
        info_raddr_a = req.node_a;
        info_raddr_b = req.node_b;
        jt_we        = 1'b0;
        jt_waddr     = {item_reg.node_a, lvl_prev};
        jt_wdata     = x_reg;
        jt_raddr_a   = {x_reg, lvl_reg};
        jt_raddr_b   = {y_reg, lvl_reg};

        unique case (state_reg)
            S_CLEAR:
            begin
                info_we    = 1'b1;
                info_waddr = clr_reg;
                info_wdata = '0;
                clr_next   = clr_reg + tlca_pkg::NODE_W'(1);
                if (clr_reg == tlca_pkg::DEPTH_MAX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    state_next = S_INFO;
                end
            end
            S_INFO:
            begin
                if (item_reg.req_type == tlca_pkg::REQ_INSERT)
                begin
                    if ((item_reg.node_a == '0) ||
                        ((item_reg.node_b != '0) && !info_b.valid))
                    begin
                        res_next   = '{ancestor: '0, status: tlca_pkg::ST_ERR};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        if (item_reg.node_b == '0)
                        begin
                            d_next = '0;
                        end
                        else if (info_b.depth != tlca_pkg::DEPTH_MAX)
                        begin
                            d_next = info_b.depth + tlca_pkg::NODE_W'(1);
                        end
                        else
                        begin
                            d_next = info_b.depth;
                        end
                        x_next     = item_reg.node_b;
                        lvl_next   = tlca_pkg::LVL_W'(1);
                        state_next = S_INS_RD;
                    end
                end
                else
                begin
                    if (!info_a.valid || !info_b.valid)
                    begin
                        res_next   = '{ancestor: '0, status: tlca_pkg::ST_ERR};
                        state_next = S_DONE;
                    end
                    else if (info_a.depth < info_b.depth)
                    begin
                        x_next     = item_reg.node_b;
                        y_next     = item_reg.node_a;
                        d_next     = info_b.depth - info_a.depth;
                        state_next = S_LVL_RD;
                    end
                    else
                    begin
                        x_next     = item_reg.node_a;
                        y_next     = item_reg.node_b;
                        d_next     = info_a.depth - info_b.depth;
                        state_next = S_LVL_RD;
                    end
                end
            end
            S_INS_RD:
            begin
                jt_raddr_a = {x_reg, lvl_prev};
                if (need_rd)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    jt_we    = 1'b1;
                    x_next   = span_ok ? x_reg : '0;
                    lvl_next = lvl_reg + tlca_pkg::LVL_W'(1);
                    state_next = (lvl_reg == tlca_pkg::LVL_TOP) ? S_INS_END : S_INS_RD;
                end
            end
            S_INS_WR:
            begin
                jt_we      = 1'b1;
                x_next     = jt_rdata_a;
                lvl_next   = lvl_reg + tlca_pkg::LVL_W'(1);
                state_next = (lvl_reg == tlca_pkg::LVL_TOP) ? S_INS_END : S_INS_RD;
            end
            S_INS_END:
            begin
                jt_we      = 1'b1;
                jt_waddr   = {item_reg.node_a, tlca_pkg::LVL_TOP};
                info_we    = 1'b1;
                info_wdata = {1'b1, d_reg};
                res_next   = '{ancestor: '0, status: tlca_pkg::ST_OK};
                state_next = S_DONE;
            end
            S_LVL_RD:
            begin
                jt_raddr_a = {x_reg, jq};
                if (d_reg == '0)
                begin
                    if (x_reg == y_reg)
                    begin
                        res_next   = '{ancestor: x_reg, status: tlca_pkg::ST_OK};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        lvl_next   = tlca_pkg::LVL_TOP;
                        state_next = S_LIFT_RD;
                    end
                end
                else
                begin
                    zx_next    = (x_reg == '0);
                    d_next     = d_reg - (tlca_pkg::NODE_W'(1) << jq);
                    state_next = S_LVL_WR;
                end
            end
            S_LVL_WR:
            begin
                x_next     = anc_a;
                state_next = S_LVL_RD;
            end
            S_LIFT_RD:
            begin
                zx_next    = (x_reg == '0);
                zy_next    = (y_reg == '0);
                state_next = S_LIFT_WR;
            end
            S_LIFT_WR:
            begin
                if (anc_a != anc_b)
                begin
                    x_next = anc_a;
                    y_next = anc_b;
                end
                if (lvl_reg == '0)
                begin
                    state_next = S_LAST_RD;
                end
                else
                begin
                    lvl_next   = lvl_prev;
                    state_next = S_LIFT_RD;
                end
            end
            S_LAST_RD:
            begin
                jt_raddr_a = {x_reg, tlca_pkg::LVL_W'(0)};
                zx_next    = (x_reg == '0);
                state_next = S_LAST_WR;
            end
            S_LAST_WR:
            begin
                res_next   = '{ancestor: anc_a, status: tlca_pkg::ST_OK};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        d_reg    <= d_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        lvl_reg  <= lvl_next;
        zx_reg   <= zx_next;
        zy_reg   <= zy_next;
        res_reg  <= res_next;
    end

endmodule

[hw/rtl/tree_lca_binary_lifting.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting: lowest common ancestor by binary lifting
// Builds a rooted forest from insert beats and answers ancestor queries.
// ----------------------------------------------------------------------------
// Usage:
//   req beats carry req_type, node_a and node_b; an insert names a node and
//   its parent (parent 0 makes a root), parents must be inserted first.
//   A query returns the lowest common ancestor of node_a and node_b.
//   Every req beat yields exactly one rsp beat, ancestor plus status.
//   One item is worked at a time, one ancestor level per step, each step
//   a lookup in the jump-table RAM, whose read data is registered.
//   req_ready is high only while the sequencer is idle.
//   After reset a clearing pass over all 1024 entries empties the node
//   table; req_ready stays low until it ends.
//   The rsp register holds a finished result while the receiver stalls; the
//   next item is accepted and worked meanwhile, and waits at its end until
//   the register frees.
// ----------------------------------------------------------------------------
module tree_lca_binary_lifting (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  tlca_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output tlca_pkg::resp_t  rsp
);

    logic            res_valid;
    logic            res_ready;
    tlca_pkg::resp_t res;

    logic            rsp_valid_reg, rsp_valid_next;
    tlca_pkg::resp_t rsp_reg, rsp_next;

    tlca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
